/* sv/eirf_pkg.sv */
// Shared types, constants and helper functions for the edge interrupt register file.
package eirf_pkg;

  // Item kinds
  localparam logic [2:0] MODE_WRITE = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_PIN   = 3'd2;
  localparam logic [2:0] MODE_TICK  = 3'd3;
  localparam logic [2:0] MODE_ACK   = 3'd4;

  // Interrupt sources
  localparam logic [1:0] SRC_TIMER  = 2'd0;
  localparam logic [1:0] SRC_ONE_HZ = 2'd1;
  localparam logic [1:0] SRC_INT1   = 2'd2;
  localparam logic [1:0] SRC_INT2   = 2'd3;

  // Register file geometry and the interrupt register address
  localparam int unsigned REG_DEPTH  = 32;
  localparam int unsigned REG_AW     = $clog2(REG_DEPTH);
  localparam logic [7:0]  INT_REG_ADDR = 8'd20;

  // Tick dividers
  localparam logic [4:0] FAST_DIVIDE = 5'd20;
  localparam logic [5:0] SLOW_DIVIDE = 6'd50;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [1:0] int_source;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pending;
  } out_word_t;

  // Interrupt state seen by a pin event
  typedef struct packed {
    logic [3:0] levels;
    logic [3:0] latches;
    logic       flag;
  } pin_state_t;

  // Request from the top level to the interrupt unit
  typedef struct packed {
    logic       fire;
    logic [2:0] mode;
    logic       int_addr;
    logic [7:0] write_data;
    logic [1:0] int_source;
  } irq_req_t;

  // Response from the interrupt unit for the item being accepted
  typedef struct packed {
    logic       irq;
    logic [7:0] int_byte;
  } irq_rsp_t;

  // Toggle a source level and latch a falling edge
  function automatic pin_state_t pin_event(pin_state_t s, logic [1:0] src);
    logic [3:0] bitmask;
    logic [3:0] lvl;
    pin_state_t r;
    bitmask = 4'b0001 << src;
    lvl     = s.levels ^ bitmask;
    r       = s;
    if ((lvl & bitmask) == 4'b0000) begin
      r.latches = s.latches | bitmask;
    end
    if (src != SRC_INT2) begin
      r.levels = lvl;
    end
    if (r.latches != 4'b0000) begin
      r.flag = 1'b1;
    end
    return r;
  endfunction

  // Interleave levels (even bits) and latches (odd bits)
  function automatic logic [7:0] pack_int(logic [3:0] levels, logic [3:0] latches);
    logic [7:0] v;
    for (int i = 0; i < 4; i++) begin
      v[2*i]   = levels[i];
      v[2*i+1] = latches[i];
    end
    return v;
  endfunction

endpackage

/* sv/eirf_ram.sv */
// Generic single-write, single-read memory with a registered read port.
module eirf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/eirf_irq_unit.sv */
// Interrupt levels, edge latches, pending flag and tick dividers.
module eirf_irq_unit (
  input  logic                clk,
  input  logic                rst,
  input  eirf_pkg::irq_req_t  req,
  output eirf_pkg::irq_rsp_t  rsp
);
  import eirf_pkg::*;

  pin_state_t st;
  pin_state_t st_next;
  logic [4:0] fast_count;
  logic [4:0] fast_count_next;
  logic [5:0] second_count;
  logic [5:0] second_count_next;
  logic [4:0] fast_inc;
  logic [5:0] second_inc;
  logic [3:0] clear_mask;

  assign fast_inc   = fast_count + 5'd1;
  assign second_inc = second_count + 6'd1;
  assign clear_mask = {req.write_data[7], req.write_data[5],
                       req.write_data[3], req.write_data[1]};

  // Work out the state after the item
  always_comb begin
    st_next           = st;
    fast_count_next   = fast_count;
    second_count_next = second_count;
    unique case (req.mode)
      MODE_WRITE: begin
        if (req.int_addr) begin
          st_next.latches = st.latches & ~clear_mask;
        end
      end
      MODE_READ: begin
        if (req.int_addr) begin
          st_next.levels = st.levels ^ 4'b1111;
        end
      end
      MODE_PIN: begin
        st_next = pin_event(st, req.int_source);
      end
      MODE_TICK: begin
        if (fast_inc == FAST_DIVIDE) begin
          fast_count_next = 5'd0;
          if (second_inc == SLOW_DIVIDE) begin
            second_count_next = 6'd0;
            st_next           = pin_event(st, SRC_ONE_HZ);
          end else begin
            second_count_next = second_inc;
          end
        end else begin
          fast_count_next = fast_inc;
        end
      end
      MODE_ACK: begin
        st_next.flag = 1'b0;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // Result fields for the item
  assign rsp.irq      = (req.mode == MODE_ACK) ? st.flag : st_next.flag;
  assign rsp.int_byte = pack_int(st_next.levels, st_next.latches);

  // Advance the state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      fast_count   <= '0;
      second_count <= '0;
    end else if (req.fire) begin
      st           <= st_next;
      fast_count   <= fast_count_next;
      second_count <= second_count_next;
    end
  end

endmodule

/* sv/edge_interrupt_register_file.sv */
// Top level: register memory, interrupt unit and the result pipeline.
// One result word per input word. The byte memory is read at the acceptance
// edge and its registered data lands in the output register after the memory
// stage. The sustained rate is one word per clock while the output is not
// stalled; the byte memory serves the one access each word needs, and
// the interrupt state lives in flip-flops updated in the acceptance cycle.
// in_stall is raised only when the memory stage and the output register are
// both full and the output is stalled. Plain reads of the 32 register bytes
// return zero after reset until written, tracked by one valid bit each.
module edge_interrupt_register_file (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  eirf_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output eirf_pkg::out_word_t  out_data
);
  import eirf_pkg::*;

  logic              accept;
  logic              int_addr;
  logic              s1_valid;
  logic              s1_ram;
  logic              s1_hit;
  logic [7:0]        s1_rd;
  logic              s1_irq;
  logic              s1_adv;
  logic              ram_we;
  logic              ram_re;
  logic [REG_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [REG_DEPTH-1:0] reg_valid;
  irq_req_t          irq_req;
  irq_rsp_t          irq_rsp;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign int_addr = (in_data.reg_address == INT_REG_ADDR);
  assign ram_addr = in_data.reg_address[REG_AW-1:0];

  // Interrupt unit request
  assign irq_req.fire       = accept;
  assign irq_req.mode       = in_data.mode;
  assign irq_req.int_addr   = int_addr;
  assign irq_req.write_data = in_data.write_data;
  assign irq_req.int_source = in_data.int_source;

  eirf_irq_unit u_irq (
    .clk (clk),
    .rst (rst),
    .req (irq_req),
    .rsp (irq_rsp)
  );

  // Memory access: plain writes, snapshot of the interrupt register, plain reads
  assign ram_we    = accept && ((in_data.mode == MODE_WRITE) ||
                                ((in_data.mode == MODE_READ) && int_addr));
  assign ram_wdata = (in_data.mode == MODE_WRITE) ? in_data.write_data
                                                  : irq_rsp.int_byte;
  assign ram_re    = accept && (in_data.mode == MODE_READ) && !int_addr;

  eirf_ram #(
    .WIDTH (8),
    .DEPTH (REG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Mark bytes written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (ram_we) begin
      reg_valid[ram_addr] <= 1'b1;
    end
  end

  // Memory stage: fill when empty, hold a waiting word while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv || !s1_valid) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ram <= ram_re;
      s1_hit <= reg_valid[ram_addr];
      s1_irq <= irq_rsp.irq;
      s1_rd  <= ((in_data.mode == MODE_READ) && int_addr) ? irq_rsp.int_byte : 8'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_data.read_data   <= s1_ram ? (s1_hit ? ram_rdata : 8'd0) : s1_rd;
      out_data.irq_pending <= s1_irq;
    end
  end

endmodule

/* sv/eirf_checker.sv */
// Port-level checks for the edge interrupt register file, bound to the top level.
module eirf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input eirf_pkg::out_word_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // Push back input only when the output side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Drop all words in flight on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // A rising out_valid must trace back to an accepted input word
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without an accepted input word");

endmodule

bind edge_interrupt_register_file eirf_checker u_eirf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the edge interrupt register file: queued stimulus, predictor, checker.
module tb_top;
  import eirf_pkg::*;

  // Item kinds the block treats as no-ops
  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

  localparam int unsigned RANDOM_WORDS   = 1700;
  localparam int unsigned TICKS_WANTED   = 1050;
  localparam int unsigned PHASE_SPAN     = 560;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  // Idle percentages per phase: receiver slow first, then sender slow, then none
  localparam int unsigned SEND_IDLE [3] = '{19, 77, 0};
  localparam int unsigned RECV_IDLE [3] = '{77, 19, 0};

  typedef struct {
    in_word_t    word;
    bit          drain_first;
    int unsigned phase_no;
  } stim_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  edge_interrupt_register_file dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  stim_t       pending_words[$];
  out_word_t   awaited_replies[$];
  int unsigned mismatches   = 0;
  int unsigned cur_phase    = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  // Stimulus bookkeeping
  int unsigned gen_phase      = 0;
  bit          gen_drain      = 1'b0;
  int unsigned words_queued   = 0;
  int unsigned ticks_queued   = 0;
  int unsigned directed_words = 0;

  // Shadow copy of the block's state
  logic [7:0] shadow_bytes [REG_DEPTH];
  logic [3:0] shadow_levels;
  logic [3:0] shadow_latches;
  logic       shadow_wanted;
  logic [4:0] shadow_fast;
  logic [5:0] shadow_seconds;

  // Toggle one source level; a falling edge sets its latch. INT2 is restored.
  function automatic void toggle_pin(logic [1:0] src);
    logic [3:0] toggled;
    toggled      = shadow_levels;
    toggled[src] = ~toggled[src];
    if (!toggled[src]) begin
      shadow_latches[src] = 1'b1;
    end
    if (src != SRC_INT2) begin
      shadow_levels = toggled;
    end
    if (shadow_latches != 4'b0000) begin
      shadow_wanted = 1'b1;
    end
  endfunction

  // Advance the shadow state by one word and return the result it produces
  function automatic out_word_t regfile_response(in_word_t w);
    out_word_t r;
    logic      flag_before;
    r.read_data   = '0;
    r.irq_pending = 1'b0;
    flag_before   = shadow_wanted;
    case (w.mode)
      MODE_WRITE: begin
        shadow_bytes[w.reg_address[4:0]] = w.write_data;
        if (w.reg_address == INT_REG_ADDR) begin
          for (int i = 0; i < 4; i++) begin
            if (w.write_data[2*i+1]) shadow_latches[i] = 1'b0;
          end
        end
      end
      MODE_READ: begin
        if (w.reg_address == INT_REG_ADDR) begin
          shadow_levels = ~shadow_levels;
          for (int i = 0; i < 4; i++) begin
            shadow_bytes[INT_REG_ADDR[4:0]][2*i]   = shadow_levels[i];
            shadow_bytes[INT_REG_ADDR[4:0]][2*i+1] = shadow_latches[i];
          end
        end
        r.read_data = shadow_bytes[w.reg_address[4:0]];
      end
      MODE_PIN: begin
        toggle_pin(w.int_source);
      end
      MODE_TICK: begin
        shadow_fast = shadow_fast + 5'd1;
        if (shadow_fast == FAST_DIVIDE) begin
          shadow_fast    = '0;
          shadow_seconds = shadow_seconds + 6'd1;
          if (shadow_seconds == SLOW_DIVIDE) begin
            shadow_seconds = '0;
            toggle_pin(SRC_ONE_HZ);
          end
        end
      end
      MODE_ACK: begin
        shadow_wanted = 1'b0;
      end
      default: begin
      end
    endcase
    r.irq_pending = (w.mode == MODE_ACK) ? flag_before : shadow_wanted;
    return r;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] any_src();
    return 2'($urandom_range(SRC_TIMER, SRC_INT2));
  endfunction

  // Favour the interrupt register and its aliases
  function automatic logic [7:0] any_address();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return INT_REG_ADDR;
    if (roll < 40) return {3'($urandom_range(1, 7)), INT_REG_ADDR[4:0]};
    return any_byte();
  endfunction

  task automatic queue_word(logic [2:0] mode, logic [7:0] addr, logic [7:0] data,
                            logic [1:0] src);
    stim_t s;
    s.word.mode        = mode;
    s.word.reg_address = addr;
    s.word.write_data  = data;
    s.word.int_source  = src;
    s.drain_first      = gen_drain;
    s.phase_no         = gen_phase;
    gen_drain          = 1'b0;
    pending_words.push_back(s);
    words_queued++;
    if (mode == MODE_TICK) ticks_queued++;
  endtask

  // Raise some edges, inspect and clear the latches, then acknowledge
  task automatic service_sequence();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) queue_word(MODE_TICK, any_byte(), any_byte(), any_src());
      else queue_word(MODE_PIN, any_byte(), any_byte(), any_src());
    end
    if ($urandom_range(0, 3) == 0) queue_word(MODE_ACK, any_byte(), any_byte(), any_src());
    queue_word(MODE_READ, INT_REG_ADDR, any_byte(), any_src());
    queue_word(MODE_WRITE, INT_REG_ADDR, any_byte(), any_src());
    if ($urandom_range(0, 1) == 0) queue_word(MODE_READ, INT_REG_ADDR, any_byte(), any_src());
    queue_word(MODE_ACK, any_byte(), any_byte(), any_src());
  endtask

  task automatic bus_traffic();
    int unsigned n;
    n = $urandom_range(2, 10);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) queue_word(MODE_WRITE, any_address(), any_byte(), any_src());
      else queue_word(MODE_READ, any_address(), any_byte(), any_src());
    end
  endtask

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Reset
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: predict each accepted word, then offer the next one
  always @(posedge clk) begin : drive_words
    stim_t head;
    if (rst) begin
      in_valid <= 1'b0;
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      shadow_levels  = '0;
      shadow_latches = '0;
      shadow_wanted  = 1'b0;
      shadow_fast    = '0;
      shadow_seconds = '0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(regfile_response(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          head = pending_words[0];
          if ((head.drain_first && awaited_replies.size() != 0) ||
              $urandom_range(0, 99) < SEND_IDLE[head.phase_no]) begin
            in_valid <= 1'b0;
          end else begin
            in_valid  <= 1'b1;
            in_data   <= head.word;
            cur_phase <= head.phase_no;
            void'(pending_words.pop_front());
          end
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected result word: read_data %0h irq_pending %0b",
                 out_data.read_data, out_data.irq_pending);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_data.read_data);
            mismatches++;
          end
          if (out_data.irq_pending !== want.irq_pending) begin
            $error("irq_pending: expected %0b, got %0b", want.irq_pending,
                   out_data.irq_pending);
            mismatches++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up to its input
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && cur_phase == 2) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < RECV_IDLE[cur_phase]);
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int unsigned roll;
    int unsigned idx;
    int unsigned next_phase;

    // Directed: extremes, aliases, every source, side effects and spare kinds
    queue_word(MODE_READ, 8'd0, any_byte(), any_src());
    queue_word(MODE_WRITE, 8'd0, 8'hFF, SRC_INT2);
    queue_word(MODE_READ, 8'd0, 8'h00, SRC_TIMER);
    queue_word(MODE_WRITE, 8'd31, 8'h55, any_src());
    queue_word(MODE_READ, 8'd31, any_byte(), any_src());
    queue_word(MODE_WRITE, {3'b001, INT_REG_ADDR[4:0]}, 8'hAA, any_src());
    queue_word(MODE_READ, {3'b001, INT_REG_ADDR[4:0]}, any_byte(), any_src());
    queue_word(MODE_READ, INT_REG_ADDR, any_byte(), any_src());
    for (int pass = 0; pass < 2; pass++) begin
      queue_word(MODE_PIN, any_byte(), any_byte(), SRC_TIMER);
      queue_word(MODE_PIN, any_byte(), any_byte(), SRC_ONE_HZ);
      queue_word(MODE_PIN, any_byte(), any_byte(), SRC_INT1);
      queue_word(MODE_PIN, any_byte(), any_byte(), SRC_INT2);
    end
    queue_word(MODE_READ, INT_REG_ADDR, any_byte(), any_src());
    queue_word(MODE_ACK, any_byte(), any_byte(), any_src());
    queue_word(MODE_ACK, any_byte(), any_byte(), any_src());
    queue_word(MODE_WRITE, INT_REG_ADDR, 8'hAA, any_src());
    queue_word(MODE_READ, INT_REG_ADDR, any_byte(), any_src());
    queue_word(MODE_TICK, any_byte(), any_byte(), any_src());
    queue_word(MODE_SPARE_LO, any_byte(), any_byte(), any_src());
    queue_word(MODE_SPARE_MID, any_byte(), any_byte(), any_src());
    queue_word(MODE_SPARE_HI, any_byte(), any_byte(), any_src());
    queue_word(MODE_WRITE, 8'd255, 8'hFF, any_src());
    queue_word(MODE_READ, 8'd255, any_byte(), any_src());
    directed_words = words_queued;

    // Random: mostly service sequences and bus traffic, tick bursts to reach the slow divider
    while (words_queued < directed_words + RANDOM_WORDS || ticks_queued < TICKS_WANTED) begin
      idx        = words_queued - directed_words;
      next_phase = (idx < PHASE_SPAN) ? 0 : (idx < 2 * PHASE_SPAN) ? 1 : 2;
      if (next_phase != gen_phase) begin
        gen_phase = next_phase;
        gen_drain = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        service_sequence();
      end else if (roll < 70) begin
        bus_traffic();
      end else if (roll < 80) begin
        repeat ($urandom_range(80, 160)) queue_word(MODE_TICK, any_byte(), any_byte(), any_src());
      end else begin
        repeat ($urandom_range(1, 5)) begin
          queue_word(3'($urandom_range(MODE_WRITE, MODE_SPARE_HI)), any_address(), any_byte(),
                     any_src());
        end
      end
    end

    // Wait for the last word to go in and every result to come back
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/eirf_pkg.sv
sv/eirf_ram.sv
sv/eirf_irq_unit.sv
sv/edge_interrupt_register_file.sv
sv/eirf_checker.sv
test/tb_top.sv
